// ===== rtl/gwm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwm_pkg: shared types and constants for the wildcard glob matcher
// Pattern capacity, byte codes, function codes and the control/status
// structs passed between the matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LIVE_W      = PATTERN_MAX + 1;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;
    localparam logic [7:0] NUL_BYTE  = 8'h00;

    typedef enum logic [1:0] {
        FUNC_APPEND  = 2'd0,
        FUNC_SUBJECT = 2'd1,
        FUNC_REPORT  = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    typedef logic [PATTERN_MAX-1:0] t_pos_vec;
    typedef logic [LIVE_W-1:0]      t_live_vec;

    // One executed item, decoded
    typedef struct packed {
        logic       append;
        logic       subject;
        logic       report;
        logic       clear;
        logic [7:0] character;
    } t_exec;

    // Pattern state as seen by the live-position tracker
    typedef struct packed {
        t_pos_vec             star;
        t_pos_vec             star_next;
        t_pos_vec             hit;
        logic [LEN_W-1:0]     len;
        logic                 ovf;
    } t_pat_stat;

endpackage

`default_nettype wire

// ===== rtl/gwm_if.sv =====
// ----------------------------------------------------------------------------
// gwm_if: item and result channels of the wildcard glob matcher
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwm_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] character;

    modport source (output valid, output func, output character, input ready);
    modport sink   (input valid, input func, input character, output ready);
endinterface

interface gwm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/wildcard_glob_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: streaming wildcard pattern matcher
// Matches a streamed subject against a stored '*' / '?' pattern.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries func and character. Func append stores a pattern byte,
//   subject feeds one subject byte, report ends the subject and returns one
//   result item on o_result, clear empties the pattern. Zero bytes given to
//   append or subject are dropped. Only report produces a result.
//   Each item is registered on acceptance and executed from that register.
//   Throughput is one item per cycle unless a report waits on o_result:
//   the whole live-position update for a byte (parallel compare of all
//   pattern bytes plus one 65-bit carry chain for star closure) sits
//   between the input register and the state.
//   Appending beyond 64 bytes sets pattern_overflow; reports then give
//   matched = 0 until a clear.
//   When o_result is stalled, non-report items keep flowing; a report waits
//   in the input register until the result register is free, and i_item
//   then holds ready low.
//   Reset empties the pattern, clears overflow and leaves only position
//   zero live; the pattern bytes themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    gwm_item_if.sink      i_item,
    gwm_result_if.source  o_result
);
    import gwm_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_func;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    logic       r_out_matched;
    logic       r_out_ovf;
    logic       w_fire;
    logic       w_end_live;
    t_exec      w_op;
    t_pat_stat  w_stat;

    // Hold a report until the result register can take it
    assign w_fire = r_in_valid
                 && ((r_in_func != FUNC_REPORT) || !r_out_valid || o_result.ready);

    assign i_item.ready = !r_in_valid || w_fire;

    always_comb begin
        w_op           = '0;
        w_op.character = r_in_char;
        if (w_fire) begin
            unique case (t_func'(r_in_func))
                FUNC_APPEND:  w_op.append  = 1'b1;
                FUNC_SUBJECT: w_op.subject = 1'b1;
                FUNC_REPORT:  w_op.report  = 1'b1;
                FUNC_CLEAR:   w_op.clear   = 1'b1;
                default:      w_op.clear   = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_func <= i_item.func;
            r_in_char <= i_item.character;
        end
    end

    gwm_pattern_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_stat  (w_stat)
    );

    gwm_live_track u_live (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_stat     (w_stat),
        .o_end_live (w_end_live)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_op.report) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op.report) begin
            r_out_matched <= !w_stat.ovf && w_end_live;
            r_out_ovf     <= w_stat.ovf;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.matched          = r_out_matched;
    assign o_result.pattern_overflow = r_out_ovf;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.clear |=> (w_stat.len == '0) && !w_stat.ovf)
        else $error("clear did not empty the pattern");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.len <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond capacity");

    a_stall_only_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> r_in_valid && (r_in_func == FUNC_REPORT) && r_out_valid)
        else $error("input stalled without a waiting report");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.report |=> !(o_result.matched && o_result.pattern_overflow))
        else $error("match reported with overflow set");

endmodule

`default_nettype wire

// ===== rtl/gwm_pattern_store.sv =====
// ----------------------------------------------------------------------------
// gwm_pattern_store: pattern byte store, length and overflow flag
// Holds the pattern bytes and compares every stored byte with the current
// subject byte in parallel, giving one step-enable bit per position.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_pattern_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gwm_pkg::t_exec    i_op,
    output gwm_pkg::t_pat_stat     o_stat
);
    import gwm_pkg::*;

    logic [7:0]       r_mem [PATTERN_MAX];
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_ovf;
    logic             n_ovf;
    t_pos_vec         r_star;
    t_pos_vec         n_star;
    t_pos_vec         w_hit;
    logic             w_room;
    logic             w_store;

    assign w_room  = (r_len < LEN_W'(PATTERN_MAX));
    assign w_store = i_op.append && (i_op.character != NUL_BYTE) && w_room;

    always_comb begin
        n_len  = r_len;
        n_ovf  = r_ovf;
        n_star = r_star;
        if (i_op.clear) begin
            n_len  = '0;
            n_ovf  = 1'b0;
            n_star = '0;
        end else if (w_store) begin
            n_len                    = r_len + LEN_W'(1);
            n_star[r_len[IDX_W-1:0]] = (i_op.character == STAR_BYTE);
        end else if (i_op.append && (i_op.character != NUL_BYTE)) begin
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_star <= '0;
        end else begin
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_star <= n_star;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_len[IDX_W-1:0]] <= i_op.character;
        end
    end

    // Positions past the pattern end never step; their bytes are stale
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cmp
        assign w_hit[j] = (LEN_W'(j) < r_len) && !r_star[j]
                        && ((r_mem[j] == ANY_BYTE) || (r_mem[j] == i_op.character));
    end

    assign o_stat.star      = r_star;
    assign o_stat.star_next = n_star;
    assign o_stat.hit       = w_hit;
    assign o_stat.len       = r_len;
    assign o_stat.ovf       = r_ovf;

endmodule

`default_nettype wire

// ===== rtl/gwm_live_track.sv =====
// ----------------------------------------------------------------------------
// gwm_live_track: live pattern positions
// One bit per pattern position, kept closed over star positions: a live
// star always makes the position after it live. The closure runs as a
// carry chain through one wide add.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_live_track (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gwm_pkg::t_exec      i_op,
    input  wire gwm_pkg::t_pat_stat  i_stat,
    output logic                     o_end_live
);
    import gwm_pkg::*;

    t_live_vec r_live;
    t_live_vec n_live;
    t_live_vec w_raw;
    t_live_vec w_prop;
    t_live_vec w_gen;
    t_live_vec w_sum;
    t_pos_vec  w_stay;
    t_pos_vec  w_step;

    assign w_stay = r_live[PATTERN_MAX-1:0] & i_stat.star;
    assign w_step = r_live[PATTERN_MAX-1:0] & i_stat.hit;

    always_comb begin
        priority if (i_op.clear || i_op.report) begin
            w_raw = LIVE_W'(1);
        end else if (i_op.subject && (i_op.character != NUL_BYTE)) begin
            w_raw = {1'b0, w_stay} | {w_step, 1'b0};
        end else begin
            w_raw = r_live;
        end
    end

    // Carry into bit i+1 = star[i] & (raw[i] | carry into bit i)
    assign w_prop = {1'b0, i_stat.star_next};
    assign w_gen  = w_raw & w_prop;
    assign w_sum  = w_prop + w_gen;
    assign n_live = w_raw | (w_sum ^ w_prop ^ w_gen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= LIVE_W'(1);
        end else begin
            r_live <= n_live;
        end
    end

    assign o_end_live = r_live[i_stat.len];

endmodule

`default_nettype wire
